[rtl/alu_pkg.sv]
// ----------------------------------------------------------------------------
// alu_pkg: shared types and constants for the 16-bit ALU with shifter
// Holds the operation codes and the transaction payload types.
// ----------------------------------------------------------------------------
`default_nettype none
package alu_pkg;
  localparam int WordWidth = 16;
  localparam int ShWidth   = 4;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,  OP_SUB  = 4'd1,  OP_MUL  = 4'd2,  OP_DIV  = 4'd3,
    OP_MOD  = 4'd4,  OP_AND  = 4'd5,  OP_OR   = 4'd6,  OP_XOR  = 4'd7,
    OP_NOT  = 4'd8,  OP_CMP  = 4'd9,  OP_SHL0 = 4'd10, OP_SHL1 = 4'd11,
    OP_SHR0 = 4'd12, OP_SHR1 = 4'd13, OP_ROTL = 4'd14, OP_ROTR = 4'd15
  } alu_op_t;

  typedef struct packed {
    logic [3:0]           mode;
    logic [WordWidth-1:0] operand_a;
    logic [WordWidth-1:0] operand_b;
    logic                 carry_in;
    logic                 use_carry;
    logic [ShWidth-1:0]   shift_amount;
  } alu_in_t;

  typedef struct packed {
    logic [WordWidth-1:0] result;
    logic carry_flag;
    logic zero_flag;
    logic negative_flag;
    logic overflow_flag;
    logic div_zero_flag;
    logic equal_flag;
    logic less_flag;
    logic greater_flag;
  } alu_out_t;
endpackage
`default_nettype wire

[rtl/alu_if.sv]
// ----------------------------------------------------------------------------
// alu_in_if / alu_out_if: valid/ready channels of the ALU
// One transaction moves when valid and ready are high at a clock edge.
// ----------------------------------------------------------------------------
`default_nettype none
interface alu_in_if import alu_pkg::*; ();
  logic    valid;
  logic    ready;
  alu_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface alu_out_if import alu_pkg::*; ();
  logic     valid;
  logic     ready;
  alu_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/alu_with_shifter.sv]
// ----------------------------------------------------------------------------
// alu_with_shifter: pipelined 16-bit ALU with barrel shifter
// ----------------------------------------------------------------------------
// Takes one transaction per cycle unless the result channel stalls, and
// returns one result per transaction in order. Each result passes through
// eighteen register stages, made of one input register, sixteen divider
// stages (one quotient bit each, which set the depth), and the output
// register. Every operation travels the same pipeline; a stall on the result
// channel freezes all stages together, so nothing is lost or repeated.
`default_nettype none
module alu_with_shifter import alu_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  alu_in_if.sink    in_ch,
  alu_out_if.source out_ch
);
  localparam int Depth = WordWidth + 2;

  logic            adv;
  logic [Depth-1:0] vld_r;
  alu_in_t          in_r;
  alu_out_t         pre_r [WordWidth+1];
  alu_op_t          op_r  [WordWidth+1];
  logic             bz_r  [WordWidth+1];
  alu_out_t         pre_nxt;
  alu_out_t         out_nxt;
  alu_out_t         out_r;
  logic [WordWidth-1:0] quo, rem;
  logic [2*WordWidth-1:0] prod;
  logic [WordWidth:0]     sum;
  logic [WordWidth-1:0]   a, b, na, rl, rr;
  logic [ShWidth-1:0]     sh;

  // Advance the whole pipeline unless a result is stuck at the output
  assign adv          = !vld_r[Depth-1] || out_ch.ready;
  assign in_ch.ready  = adv;
  assign out_ch.valid = vld_r[Depth-1];
  assign out_ch.data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[Depth-2:0], in_ch.valid};
    end
  end

  // Capture the transaction
  always_ff @(posedge clk) begin
    if (adv) begin
      in_r <= in_ch.data;
    end
  end

  // Stage one: everything except division
  always_comb begin
    a    = in_r.operand_a;
    b    = in_r.operand_b;
    sh   = in_r.shift_amount;
    na   = ~a;
    prod = a * b;
    sum  = {1'b0, a} + {1'b0, b} + {{WordWidth{1'b0}}, in_r.use_carry & in_r.carry_in};
    rl   = (a << sh) | (a >> (WordWidth[ShWidth:0] - {1'b0, sh}));
    rr   = (a >> sh) | (a << (WordWidth[ShWidth:0] - {1'b0, sh}));
    pre_nxt = '0;
    case (alu_op_t'(in_r.mode))
      OP_ADD: begin
        pre_nxt.result     = sum[WordWidth-1:0];
        pre_nxt.carry_flag = sum[WordWidth];
      end
      OP_SUB: begin
        pre_nxt.result        = a - b;
        pre_nxt.negative_flag = a < b;
      end
      OP_MUL: begin
        pre_nxt.result        = prod[WordWidth-1:0];
        pre_nxt.overflow_flag = |prod[2*WordWidth-1:WordWidth];
      end
      OP_DIV, OP_MOD: pre_nxt.div_zero_flag = (b == '0);
      OP_AND: pre_nxt.result = a & b;
      OP_OR:  pre_nxt.result = a | b;
      OP_XOR: pre_nxt.result = a ^ b;
      OP_NOT: pre_nxt.result = na;
      OP_CMP: begin
        pre_nxt.result       = a;
        pre_nxt.equal_flag   = a == b;
        pre_nxt.less_flag    = a < b;
        pre_nxt.greater_flag = a > b;
      end
      OP_SHL0: pre_nxt.result = a << sh;
      OP_SHL1: pre_nxt.result = ~(na << sh);
      OP_SHR0: pre_nxt.result = a >> sh;
      OP_SHR1: pre_nxt.result = ~(na >> sh);
      OP_ROTL: pre_nxt.result = (sh == '0) ? a : rl;
      default: pre_nxt.result = (sh == '0) ? a : rr;
    endcase
  end

  alu_div u_div (
    .clk       (clk),
    .en        (adv),
    .dividend  (in_r.operand_a),
    .divisor   (in_r.operand_b),
    .quotient  (quo),
    .remainder (rem)
  );

  // Carry the early result alongside the divider
  always_comb begin
    pre_r[0] = pre_nxt;
    op_r[0]  = alu_op_t'(in_r.mode);
    bz_r[0]  = (in_r.operand_b == '0);
  end

  for (genvar i = 0; i < WordWidth; i++) begin : g_dly
    always_ff @(posedge clk) begin
      if (adv) begin
        pre_r[i+1] <= pre_r[i];
        op_r[i+1]  <= op_r[i];
        bz_r[i+1]  <= bz_r[i];
      end
    end
  end

  // Final select and zero flag
  always_comb begin
    out_nxt = pre_r[WordWidth];
    if (op_r[WordWidth] == OP_DIV || op_r[WordWidth] == OP_MOD) begin
      if (bz_r[WordWidth]) begin
        out_nxt.result = '0;
      end else if (op_r[WordWidth] == OP_DIV) begin
        out_nxt.result = quo;
      end else begin
        out_nxt.result = rem;
      end
    end
    out_nxt.zero_flag = (op_r[WordWidth] <= OP_NOT) && (out_nxt.result == '0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  // Hold the output while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("output changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty output");
  a_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> $countones({out_ch.data.equal_flag, out_ch.data.less_flag,
                                 out_ch.data.greater_flag}) <= 1)
    else $error("compare flags not exclusive");
  a_dz: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.div_zero_flag |->
      out_ch.data.result == '0 && out_ch.data.zero_flag)
    else $error("divide by zero result not cleared");
endmodule
`default_nettype wire

[rtl/alu_div.sv]
// ----------------------------------------------------------------------------
// alu_div: pipelined restoring divider
// Resolves one quotient bit per stage; the pipeline advances on enable.
// ----------------------------------------------------------------------------
`default_nettype none
module alu_div import alu_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [WordWidth-1:0] dividend,
  input  wire logic [WordWidth-1:0] divisor,
  output logic      [WordWidth-1:0] quotient,
  output logic      [WordWidth-1:0] remainder
);
  logic [WordWidth-1:0] rem_r [WordWidth+1];
  logic [WordWidth-1:0] quo_r [WordWidth+1];
  logic [WordWidth-1:0] dvs_r [WordWidth+1];

  always_comb begin
    rem_r[0] = '0;
    quo_r[0] = dividend;
    dvs_r[0] = divisor;
  end

  // Resolve one quotient bit per stage, MSB first
  for (genvar i = 0; i < WordWidth; i++) begin : g_stage
    logic [WordWidth:0]   trial;
    logic [WordWidth-1:0] rem_nxt;
    logic [WordWidth-1:0] quo_nxt;
    always_comb begin
      trial   = {rem_r[i], quo_r[i][WordWidth-1]} - {1'b0, dvs_r[i]};
      quo_nxt = {quo_r[i][WordWidth-2:0], ~trial[WordWidth]};
      if (trial[WordWidth]) begin
        rem_nxt = {rem_r[i][WordWidth-2:0], quo_r[i][WordWidth-1]};
      end else begin
        rem_nxt = trial[WordWidth-1:0];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= rem_nxt;
        quo_r[i+1] <= quo_nxt;
        dvs_r[i+1] <= dvs_r[i];
      end
    end
  end

  assign quotient  = quo_r[WordWidth];
  assign remainder = rem_r[WordWidth];
endmodule
`default_nettype wire
